FILE: src/fdss_pkg.sv
// Shared types and constants for the floppy drive select/step/status core.
// No dependencies.
`default_nettype none
package fdss_pkg;

    localparam logic [2:0] ACT_PORTB  = 3'd0;
    localparam logic [2:0] ACT_STATUS = 3'd1;
    localparam logic [2:0] ACT_FRAME  = 3'd2;
    localparam logic [2:0] ACT_MEDIA  = 3'd3;
    localparam logic [2:0] ACT_RESET  = 3'd4;

    // port B bit positions
    localparam int PB_STEP_N = 0;
    localparam int PB_DIR    = 1;
    localparam int PB_SIDE_N = 2;
    localparam int PB_SEL_N  = 3;
    localparam int PB_MTR_N  = 7;

    // port A bit positions (active low)
    localparam int PA_CHANGE = 2;
    localparam int PA_TRACK0 = 4;
    localparam int PA_READY  = 5;
    localparam int PA_LMB    = 6;
    localparam int PA_FIRE   = 7;

    localparam int CYL_W = 7;
    localparam int DIV_W = 4;

    typedef struct packed {
        logic [7:0]       status_byte;
        logic [CYL_W-1:0] cylinder;
        logic             head_side;
        logic             motor_on;
        logic             index_pulse;
        logic             track_readable;
    } result_t;

endpackage
`default_nettype wire

FILE: src/floppy_drive_select_step_status_core.sv
// Top level of the floppy drive select/step/status core: handshake and skid.
// Depends on fdss_pkg and fdss_drive.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: action, port_value,
//   disk_present, left_button, fire_button. Output channel (out_valid /
//   out_stall) carries one result item per input item, in order.
//   An item is taken on a rising edge with valid high and stall low.
//   The result goes into the output register, or the skid register while
//   the output is held. Throughput: one item per cycle while in_stall is
//   low; drive state updates as each item is taken, so items may follow back to back.
//   When the receiver stalls, the output register holds its result and a
//   one-entry skid register takes one more item; in_stall rises only while
//   the skid entry is full.
//   Reset (rst_n low, asynchronous) clears all drive state to its power-up
//   values and empties the output and skid registers.
`default_nettype none
module floppy_drive_select_step_status_core #(
    parameter int MAX_CYLINDER = 82,
    parameter int INDEX_DIVIDE = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] action,
    input  wire logic [7:0] port_value,
    input  wire logic       disk_present,
    input  wire logic       left_button,
    input  wire logic       fire_button,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      status_byte,
    output logic [6:0]      cylinder,
    output logic            head_side,
    output logic            motor_on,
    output logic            index_pulse,
    output logic            track_readable
);
    import fdss_pkg::*;

    result_t res;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    pop;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign pop      = out_valid_reg & ~out_stall;

    fdss_drive #(
        .MAX_CYLINDER(MAX_CYLINDER),
        .INDEX_DIVIDE(INDEX_DIVIDE)
    ) u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .port_value  (port_value),
        .disk_present(disk_present),
        .left_button (left_button),
        .fire_button (fire_button),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status_byte    = out_data_reg.status_byte;
    assign cylinder       = out_data_reg.cylinder;
    assign head_side      = out_data_reg.head_side;
    assign motor_on       = out_data_reg.motor_on;
    assign index_pulse    = out_data_reg.index_pulse;
    assign track_readable = out_data_reg.track_readable;

endmodule
`default_nettype wire

FILE: src/fdss_drive.sv
// Drive state registers and per-item update; produces the result of the item.
// Depends on fdss_pkg.
`default_nettype none
module fdss_drive #(
    parameter int MAX_CYLINDER = 82,
    parameter int INDEX_DIVIDE = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [2:0]       action,
    input  wire logic [7:0]       port_value,
    input  wire logic             disk_present,
    input  wire logic             left_button,
    input  wire logic             fire_button,
    output fdss_pkg::result_t     result
);
    import fdss_pkg::*;

    localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(MAX_CYLINDER);
    localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(INDEX_DIVIDE);

    logic [CYL_W-1:0] cyl_reg, cyl_next;
    logic             side_reg, side_next;
    logic             motor_reg, motor_next;
    logic             sel_reg, sel_next;
    logic             step_reg, step_next;
    logic             chg_reg, chg_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] div_inc;
    logic             pulse;
    logic             sel_in;

    always_comb
    begin
        cyl_next   = cyl_reg;
        side_next  = side_reg;
        motor_next = motor_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        chg_next   = chg_reg;
        div_next   = div_reg;
        pulse      = 1'b0;
        sel_in     = ~port_value[PB_SEL_N];
        div_inc    = div_reg + DIV_W'(1);
        unique case (action)
            ACT_PORTB:
            begin
                side_next = ~port_value[PB_SIDE_N];
                if (sel_in && !sel_reg)
                begin
                    motor_next = ~port_value[PB_MTR_N];
                end
                sel_next = sel_in;
                if (sel_in && step_reg && !port_value[PB_STEP_N])
                begin
                    if (port_value[PB_DIR])
                    begin
                        if (cyl_reg != '0)
                        begin
                            cyl_next = cyl_reg - CYL_W'(1);
                        end
                    end
                    else if (cyl_reg < CYL_MAX)
                    begin
                        cyl_next = cyl_reg + CYL_W'(1);
                    end
                    if (disk_present)
                    begin
                        chg_next = 1'b0;
                    end
                end
                step_next = port_value[PB_STEP_N];
            end
            ACT_FRAME:
            begin
                if (motor_reg)
                begin
                    if (div_inc >= DIV_MAX)
                    begin
                        div_next = '0;
                        pulse    = 1'b1;
                    end
                    else
                    begin
                        div_next = div_inc;
                    end
                end
            end
            ACT_MEDIA:
            begin
                chg_next = 1'b1;
            end
            ACT_RESET:
            begin
                step_next  = 1'b1;
                motor_next = 1'b0;
                sel_next   = 1'b0;
            end
            default:
            begin
                // status read and unused codes: no state change
            end
        endcase
    end

    always_comb
    begin
        result.status_byte = 8'hFF;
        if (left_button)
        begin
            result.status_byte[PA_LMB] = 1'b0;
        end
        if (fire_button)
        begin
            result.status_byte[PA_FIRE] = 1'b0;
        end
        if (!disk_present || chg_next)
        begin
            result.status_byte[PA_CHANGE] = 1'b0;
        end
        if (cyl_next == '0)
        begin
            result.status_byte[PA_TRACK0] = 1'b0;
        end
        if (sel_next && (!motor_next || disk_present))
        begin
            result.status_byte[PA_READY] = 1'b0;
        end
        result.cylinder       = cyl_next;
        result.head_side      = side_next;
        result.motor_on       = motor_next;
        result.index_pulse    = pulse;
        result.track_readable = disk_present & sel_next & motor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_reg   <= '0;
            side_reg  <= 1'b0;
            motor_reg <= 1'b0;
            sel_reg   <= 1'b0;
            step_reg  <= 1'b1;
            chg_reg   <= 1'b1;
            div_reg   <= '0;
        end
        else if (accept)
        begin
            cyl_reg   <= cyl_next;
            side_reg  <= side_next;
            motor_reg <= motor_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
            chg_reg   <= chg_next;
            div_reg   <= div_next;
        end
    end

endmodule
`default_nettype wire

FILE: tb/floppy_drive_select_step_status_core_test.sv
// Self-checking testbench for floppy_drive_select_step_status_core: directed and random
// port B / status / frame / media / reset items, checked against a cycle-free drive model.
// Depends on fdss_pkg and the core RTL.
`timescale 1ns / 100ps
module floppy_drive_select_step_status_core_test;
    import fdss_pkg::*;

    localparam int MAX_CYL     = 82;
    localparam int INDEX_DIV   = 10;
    localparam int RANDOM_OPS  = 1400;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 31;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] pv;
        logic       disk;
        logic       lmb;
        logic       fire;
    } drive_op_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] action = ACT_STATUS;
    logic [7:0] port_value = 8'h00;
    logic       disk_present = 1'b0;
    logic       left_button = 1'b0;
    logic       fire_button = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] status_byte;
    logic [6:0] cylinder;
    logic       head_side;
    logic       motor_on;
    logic       index_pulse;
    logic       track_readable;

    drive_op_t pending_ops[$];
    result_t   expected_results[$];
    int        sent_count = 0;
    int        received_count = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        holdoff_left = 0;
    logic      holdoff_done = 1'b0;

    // drive model state
    logic [CYL_W-1:0] cyl_q = '0;
    logic             side_q = 1'b0;
    logic             motor_q = 1'b0;
    logic             selected_q = 1'b0;
    logic             step_line_q = 1'b1;
    logic             changed_q = 1'b1;
    logic [DIV_W-1:0] divider_q = '0;

    floppy_drive_select_step_status_core #(
        .MAX_CYLINDER(MAX_CYL),
        .INDEX_DIVIDE(INDEX_DIV)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .port_value(port_value),
        .disk_present(disk_present),
        .left_button(left_button),
        .fire_button(fire_button),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status_byte(status_byte),
        .cylinder(cylinder),
        .head_side(head_side),
        .motor_on(motor_on),
        .index_pulse(index_pulse),
        .track_readable(track_readable)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t advance_drive(input logic [2:0] op, input logic [7:0] pv,
                                              input logic disk, input logic lmb,
                                              input logic fire);
        result_t          r;
        logic             pulse;
        logic             sel_now;
        logic [DIV_W-1:0] div_next;
        pulse = 1'b0;
        case (op)
            ACT_PORTB:
            begin
                sel_now = !pv[PB_SEL_N];
                side_q = !pv[PB_SIDE_N];
                if (sel_now && !selected_q)
                    motor_q = !pv[PB_MTR_N];
                selected_q = sel_now;
                if (selected_q && step_line_q && !pv[PB_STEP_N])
                begin
                    if (pv[PB_DIR])
                    begin
                        if (cyl_q != 0)
                            cyl_q = cyl_q - 1'b1;
                    end
                    else if (cyl_q < MAX_CYL)
                        cyl_q = cyl_q + 1'b1;
                    if (disk)
                        changed_q = 1'b0;
                end
                step_line_q = pv[PB_STEP_N];
            end
            ACT_FRAME:
            begin
                if (motor_q)
                begin
                    div_next = divider_q + 1'b1;
                    if (div_next >= INDEX_DIV)
                    begin
                        divider_q = '0;
                        pulse = 1'b1;
                    end
                    else
                        divider_q = div_next;
                end
            end
            ACT_MEDIA:
                changed_q = 1'b1;
            ACT_RESET:
            begin
                step_line_q = 1'b1;
                motor_q = 1'b0;
                selected_q = 1'b0;
            end
            default:
                ;
        endcase
        r.status_byte = 8'hFF;
        if (lmb)
            r.status_byte[PA_LMB] = 1'b0;
        if (fire)
            r.status_byte[PA_FIRE] = 1'b0;
        if (!disk || changed_q)
            r.status_byte[PA_CHANGE] = 1'b0;
        if (cyl_q == 0)
            r.status_byte[PA_TRACK0] = 1'b0;
        if (selected_q && (motor_q ? disk : 1'b1))
            r.status_byte[PA_READY] = 1'b0;
        r.cylinder = cyl_q;
        r.head_side = side_q;
        r.motor_on = motor_q;
        r.index_pulse = pulse;
        r.track_readable = disk && selected_q && motor_q;
        return r;
    endfunction

    task automatic add_op(input logic [2:0] op, input logic [7:0] pv, input logic disk);
        pending_ops.insert(pending_ops.size(), {op, pv, disk, 1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1))});
    endtask

    // well-formed sequences with random content, plus some noise
    task automatic add_random_burst();
        int         kind;
        int         n;
        logic [7:0] base;
        logic [7:0] pv;
        logic       disk;
        kind = $urandom_range(0, 9);
        disk = ($urandom_range(0, 9) != 0);
        base = 8'($urandom);
        if (kind < 4)
        begin
            base[PB_SEL_N] = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 1))
            begin
                pv = base;
                pv[PB_SEL_N] = 1'b1;
                add_op(ACT_PORTB, pv, disk);
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                pv = base;
                pv[6:4] = 3'($urandom);
                pv[PB_SIDE_N] = 1'($urandom_range(0, 1));
                pv[PB_STEP_N] = 1'b1;
                add_op(ACT_PORTB, pv, disk);
                pv[PB_STEP_N] = 1'b0;
                add_op(ACT_PORTB, pv, disk);
            end
        end
        else if (kind < 6)
        begin
            n = $urandom_range(1, 25);
            for (int i = 0; i < n; i++)
                add_op(ACT_FRAME, 8'($urandom), disk);
        end
        else if (kind == 6)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_op(ACT_STATUS, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        else if (kind == 7)
            add_op($urandom_range(0, 1) ? ACT_MEDIA : ACT_RESET, 8'($urandom), disk);
        else
            add_op(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.insert(expected_results.size(),
                                        advance_drive(action, port_value, disk_present,
                                                      left_button, fire_button));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_ops.size() != 0 &&
                    ((sent_count >= 600 && sent_count < 800) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    action <= pending_ops[0].op;
                    port_value <= pending_ops[0].pv;
                    disk_present <= pending_ops[0].disk;
                    left_button <= pending_ops[0].lmb;
                    fire_button <= pending_ops[0].fire;
                    in_valid <= 1'b1;
                    void'(pending_ops.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the skid fills and the input stalls
    always @(posedge clk)
    begin
        if (!holdoff_done && sent_count >= 300)
        begin
            holdoff_left <= 80;
            holdoff_done <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // receiver and checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no item pending, actual status %02h cyl %0d",
                             $time, status_byte, cylinder);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status_byte", int'(want.status_byte), int'(status_byte));
                    check_field("cylinder", int'(want.cylinder), int'(cylinder));
                    check_field("head_side", int'(want.head_side), int'(head_side));
                    check_field("motor_on", int'(want.motor_on), int'(motor_on));
                    check_field("index_pulse", int'(want.index_pulse), int'(index_pulse));
                    check_field("track_readable", int'(want.track_readable),
                                int'(track_readable));
                end
                received_count <= received_count + 1;
            end
            out_stall <= (holdoff_left != 0) ||
                         (!(received_count >= 600 && received_count < 800) &&
                          $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("floppy_drive_select_step_status_core_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int directed_count;
        // directed: reset state, stepping at cylinder 0, motor latch, deselected step,
        // media, soft reset, unused codes, ignored port bits
        add_op(ACT_STATUS, 8'h00, 1'b0);
        pending_ops.insert(pending_ops.size(), {ACT_STATUS, 8'hFF, 1'b1, 1'b1, 1'b1});
        add_op(ACT_PORTB, 8'h03, 1'b1);
        add_op(ACT_PORTB, 8'h02, 1'b1);
        add_op(ACT_PORTB, 8'h01, 1'b1);
        add_op(ACT_PORTB, 8'h00, 1'b1);
        add_op(ACT_PORTB, 8'h70, 1'b0);
        add_op(ACT_FRAME, 8'hFF, 1'b1);
        add_op(ACT_PORTB, 8'h8D, 1'b1);
        add_op(ACT_PORTB, 8'h8C, 1'b1);
        add_op(ACT_STATUS, 8'h00, 1'b1);
        add_op(ACT_MEDIA, 8'h00, 1'b1);
        add_op(ACT_PORTB, 8'h07, 1'b0);
        add_op(ACT_PORTB, 8'h06, 1'b0);
        add_op(ACT_RESET, 8'hFF, 1'b1);
        add_op(3'd5, 8'hFF, 1'b1);
        add_op(3'd6, 8'h00, 1'b0);
        add_op(3'd7, 8'hAA, 1'b1);
        add_op(ACT_PORTB, 8'hFF, 1'b1);
        add_op(ACT_PORTB, 8'h81, 1'b1);
        add_op(ACT_STATUS, 8'h55, 1'b0);
        add_op(ACT_PORTB, 8'h80, 1'b1);
        add_op(ACT_FRAME, 8'h00, 1'b0);
        add_op(ACT_STATUS, 8'h00, 1'b1);
        directed_count = pending_ops.size();
        while (pending_ops.size() < directed_count + RANDOM_OPS)
            add_random_burst();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("floppy_drive_select_step_status_core_test OK");
        else
            $display("floppy_drive_select_step_status_core_test NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/fdss_pkg.sv
src/fdss_drive.sv
src/floppy_drive_select_step_status_core.sv
tb/floppy_drive_select_step_status_core_test.sv
